[src/qpd_pkg.sv]
package qpd_pkg;

    localparam logic [7:0] QP_EQ = 8'h3D;
    localparam logic [7:0] QP_CR = 8'h0D;
    localparam logic [7:0] QP_LF = 8'h0A;

    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_EQ   = 2'd1,
        HELD_PAIR = 2'd2,
        HELD_BAD  = 2'd3
    } held_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       out_last;
    } qpd_res_t;

    typedef struct packed {
        qpd_res_t [MAX_RES-1:0] res;
        logic [1:0]             n;
    } qpd_batch_t;

    typedef struct packed {
        qpd_batch_t batch;
        held_t      cnt;
        logic [7:0] fol;
    } qpd_step_t;

    function automatic qpd_res_t data_res(input logic [7:0] b);
        qpd_res_t r;
        begin
            r.out_byte = b;
            r.has_data = 1'b1;
            r.out_last = 1'b0;
            return r;
        end
    endfunction

    // valid flag and digit value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        begin
            d = '0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            begin
                d = {1'b1, c[3:0] + 4'd9};
            end
            return d;
        end
    endfunction

    function automatic qpd_step_t qpd_step(
        input held_t      cnt,
        input logic [7:0] fol,
        input logic [7:0] b,
        input logic       last
    );
        qpd_step_t  s;
        held_t      c;
        logic [7:0] h;
        logic [1:0] n;
        logic [4:0] hi;
        logic [4:0] lo;
        begin
            s  = '0;
            n  = 2'd0;
            c  = cnt;
            h  = fol;
            hi = hex_digit(fol);
            lo = hex_digit(b);
            if (c != HELD_PAIR)
            begin
                if (c == HELD_EQ)
                begin
                    c = HELD_PAIR;
                    h = b;
                end
                else if (b == QP_EQ)
                begin
                    c = HELD_EQ;
                end
                else
                begin
                    c = HELD_NONE;
                    s.batch.res[n] = data_res(b);
                    n = n + 2'd1;
                end
            end
            else
            begin
                c = HELD_NONE;
                h = 8'h00;
                if (fol == QP_CR || fol == QP_LF)
                begin
                    // soft line break
                    if (!(fol == QP_CR && b == QP_LF))
                    begin
                        if (b == QP_EQ)
                        begin
                            c = HELD_EQ;
                        end
                        else
                        begin
                            s.batch.res[n] = data_res(b);
                            n = n + 2'd1;
                        end
                    end
                end
                else if (hi[4] && lo[4])
                begin
                    s.batch.res[n] = data_res({hi[3:0], lo[3:0]});
                    n = n + 2'd1;
                end
                else
                begin
                    // bad escape: pass the '=' and decode the held bytes again
                    s.batch.res[n] = data_res(QP_EQ);
                    n = n + 2'd1;
                    if (fol == QP_EQ)
                    begin
                        c = HELD_EQ;
                    end
                    else
                    begin
                        s.batch.res[n] = data_res(fol);
                        n = n + 2'd1;
                    end
                    if (c == HELD_EQ)
                    begin
                        c = HELD_PAIR;
                        h = b;
                    end
                    else if (b == QP_EQ)
                    begin
                        c = HELD_EQ;
                    end
                    else
                    begin
                        s.batch.res[n] = data_res(b);
                        n = n + 2'd1;
                    end
                end
            end
            if (last)
            begin
                if (c == HELD_EQ)
                begin
                    s.batch.res[n] = data_res(QP_EQ);
                    n = n + 2'd1;
                end
                else if (c == HELD_PAIR)
                begin
                    s.batch.res[n] = data_res(QP_EQ);
                    n = n + 2'd1;
                    s.batch.res[n] = data_res(h);
                    n = n + 2'd1;
                end
                c = HELD_NONE;
                h = 8'h00;
                if (n == 2'd0)
                begin
                    s.batch.res[0].out_byte = 8'h00;
                    s.batch.res[0].has_data = 1'b0;
                    s.batch.res[0].out_last = 1'b1;
                    n = 2'd1;
                end
                else
                begin
                    s.batch.res[n - 2'd1].out_last = 1'b1;
                end
            end
            s.batch.n = n;
            s.cnt     = c;
            s.fol     = h;
            return s;
        end
    endfunction

endpackage

[src/qpd_ifs.sv]
interface qpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;

    modport source (output valid, output out_byte, output has_data, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input has_data, input out_last,
                  output ready);
endinterface

[src/qpd_step.sv]
module qpd_step (
    input  logic               clk,
    input  logic               rst_n,
    qpd_in_if.sink             enc,
    input  logic               room,
    output logic               fire,
    output qpd_pkg::qpd_batch_t batch
);

    logic                valid_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    qpd_pkg::held_t      cnt_reg;
    logic [7:0]          fol_reg;
    qpd_pkg::qpd_step_t  step;
    logic                take;

    assign fire      = valid_reg && room;
    assign enc.ready = !valid_reg || room;
    assign take      = enc.valid && enc.ready;

    always_comb
    begin
        step  = qpd_pkg::qpd_step(cnt_reg, fol_reg, byte_reg, last_reg);
        batch = step.batch;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enc.ready)
        begin
            valid_reg <= enc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= enc.in_byte;
            last_reg <= enc.in_last;
        end
    end

    // held escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= qpd_pkg::HELD_NONE;
            fol_reg <= 8'h00;
        end
        else if (fire)
        begin
            cnt_reg <= step.cnt;
            fol_reg <= step.fol;
        end
    end

endmodule

[src/qpd_outq.sv]
module qpd_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  qpd_pkg::qpd_batch_t batch,
    output logic                room,
    qpd_out_if.source           dec
);

    qpd_pkg::qpd_res_t [qpd_pkg::MAX_RES-1:0] q_reg;
    qpd_pkg::qpd_res_t [qpd_pkg::MAX_RES-1:0] q_next;
    logic [1:0]                               qc_reg;
    logic [1:0]                               qc_next;
    logic                                     pop;

    assign pop  = (qc_reg != 2'd0) && dec.ready;
    assign room = (qc_reg == 2'd0) || (qc_reg == 2'd1 && pop);

    assign dec.valid    = qc_reg != 2'd0;
    assign dec.out_byte = q_reg[0].out_byte;
    assign dec.has_data = q_reg[0].has_data;
    assign dec.out_last = q_reg[0].out_last;

    always_comb
    begin
        q_next  = q_reg;
        qc_next = qc_reg;
        if (fire)
        begin
            q_next  = batch.res;
            qc_next = batch.n;
        end
        else if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            qc_next   = qc_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_reg <= 2'd0;
        end
        else
        begin
            qc_reg <= qc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

[src/quoted_printable_decoder_core.sv]
// Quoted-printable decoder. Takes one encoded byte per cycle on enc, while
// the result register has room, and delivers decoded bytes on dec; the first
// result of a request passes through the input register and then the result
// register. A hex escape's last byte or a plain byte gives one result; a
// soft line break gives none; an invalid escape or a stream end with a held
// '=' gives up to three, and the three-entry result register then holds enc
// while it drains. Bytes that only start an escape give no result. The
// request with in_last set always gives at least one result, the last
// carrying out_last; a bare end marker has has_data low.
module quoted_printable_decoder_core (
    input  logic      clk,
    input  logic      rst_n,
    qpd_in_if.sink    enc,
    qpd_out_if.source dec
);

    logic                room;
    logic                fire;
    qpd_pkg::qpd_batch_t batch;

    qpd_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc),
        .room  (room),
        .fire  (fire),
        .batch (batch)
    );

    qpd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .batch (batch),
        .room  (room),
        .dec   (dec)
    );

endmodule

[src/qpd_checker.sv]
module qpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       enc_ready,
    input logic       dec_valid,
    input logic       dec_ready,
    input logic [7:0] dec_out_byte,
    input logic       dec_has_data,
    input logic       dec_out_last
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(dec_out_byte)
            && $stable(dec_has_data) && $stable(dec_out_last))
        else $error("stalled result changed");

    // bare marker only at stream end
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_has_data |-> dec_out_last)
        else $error("empty result without end mark");

    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_has_data |-> dec_out_byte == 8'h00)
        else $error("empty result carries a byte");

    // empty result register always takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !dec_valid |-> enc_ready)
        else $error("input stalled with no pending result");

endmodule

bind quoted_printable_decoder_core qpd_checker u_qpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .enc_ready    (enc.ready),
    .dec_valid    (dec.valid),
    .dec_ready    (dec.ready),
    .dec_out_byte (dec.out_byte),
    .dec_has_data (dec.has_data),
    .dec_out_last (dec.out_last)
);
